FILE: hw/rtl/ssi_pkg.sv
// Shared constants, types and status codes of the sorted sample interpolator.
`default_nettype none
package ssi_pkg;
	localparam int CAPACITY = 4096;
	localparam int TRIM_CNT = CAPACITY / 4;
	localparam int DEPTH    = CAPACITY + 1;
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int TIME_W   = 40;
	localparam int COUNT_W  = 13;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_TRIMMED  = 3'd1,
		ST_DUP      = 3'd2,
		ST_INVALID  = 3'd3,
		ST_EXACT    = 3'd4,
		ST_INTERP   = 3'd5,
		ST_NOEST    = 3'd6
	} status_t;

	typedef struct packed {
		logic              we;
		logic [CW-1:0]     waddr;
		logic [KEY_W-1:0]  wkey;
		logic [TIME_W-1:0] wtime;
		logic [CW-1:0]     raddr;
	} mem_req_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sorted_sample_interpolator.sv
// Top level: sequencer over the sorted sample table and the scaling unit.
//
// Channel  Dir  Content
// s_*      in   tuser[0] cmd; tdata[31:0] sample_id, [71:32] sample_time
// m_*      out  tuser[2:0] status; tdata[39:0] estimate_time, [52:40] entry_count
//
// One command at a time. A search runs on the single table read port. An
// insert then moves each later entry once, one entry per cycle; a trim
// then also moves 3/4 of the table. An interpolation adds two neighbor
// reads and 40 steps in the serial scaler.
// Reset clears the entry count but not the table memory.
// A new command is taken while a finished result still waits on m_*.
`default_nettype none
module sorted_sample_interpolator import ssi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // sample_id, sample_time
	input  wire logic [0:0]  s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // estimate_time, entry_count, zero fill
	output logic      [2:0]  m_tuser   // status
);
	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_SRCH_RD  = 11'b00000000010,
		S_SRCH_CMP = 11'b00000000100,
		S_EQ_CHK   = 11'b00000001000,
		S_COPY     = 11'b00000010000,
		S_INS_WR   = 11'b00000100000,
		S_EST_CAPT = 11'b00001000000,
		S_SCALE    = 11'b00010000000,
		S_FIN      = 11'b00100000000,
		S_EQ_RD    = 11'b01000000000,
		S_EST_RD0  = 11'b10000000000
	} state_t;

	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] TRIM_C = CW'(TRIM_CNT);
	localparam logic [CW-1:0] KEEP_C = CW'(CAPACITY + 1 - TRIM_CNT);

	state_t            state_q;
	logic              cmd_q;
	logic [KEY_W-1:0]  id_q;
	logic [TIME_W-1:0] tm_q;
	logic [CW-1:0]     fill_q, lo_q, hi_q, mid;
	status_t           status_q;
	logic [TIME_W-1:0] est_q;
	logic [KEY_W-1:0]  k1_q;
	logic [TIME_W-1:0] t1_q, t0_q;
	logic              up_q;
	logic [CW-1:0]     src_q, left_q, pa_q;
	logic              pv_q, trim_q;
	mem_req_t          req;
	logic [KEY_W-1:0]  rd_key;
	logic [TIME_W-1:0] rd_time;
	logic              sc_start, sc_done;
	logic [TIME_W-1:0] sc_a, sc_quo;
	logic [KEY_W-1:0]  sc_num, sc_den;
	logic              in_acc;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	ssi_table u_table (.clk(clk), .req(req), .rd_key(rd_key), .rd_time(rd_time));

	ssi_scale u_scale (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .a(sc_a),
		.num(sc_num), .den(sc_den), .done(sc_done), .quo(sc_quo)
	);

	// Scaler operands combine the lower neighbor read with the query and the held upper neighbor.
	always_comb begin
		sc_start = (state_q == S_EST_CAPT);
		sc_num   = id_q - rd_key;
		sc_den   = k1_q - rd_key;
		sc_a     = (t1_q >= rd_time) ? (t1_q - rd_time) : (rd_time - t1_q);
	end

	// Memory port: read address per state, writes from the copy pipe or insert.
	always_comb begin
		req.raddr = lo_q;
		req.we    = 1'b0;
		req.waddr = up_q ? pa_q + 1'b1 : pa_q - TRIM_C;
		req.wkey  = rd_key;
		req.wtime = rd_time;
		case (state_q)
			S_SRCH_RD: req.raddr = mid;
			S_EST_RD0: req.raddr = lo_q - 1'b1;
			S_COPY: begin
				req.raddr = src_q;
				req.we    = pv_q;
			end
			S_INS_WR: begin
				req.we    = 1'b1;
				req.waddr = lo_q;
				req.wkey  = id_q;
				req.wtime = tm_q;
			end
			default: req.raddr = lo_q;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			m_tvalid <= 1'b0;
			pv_q     <= 1'b0;
			left_q   <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_FIN) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= s_tuser[0];
						id_q  <= s_tdata[31:0];
						tm_q  <= s_tdata[71:32];
						est_q <= '0;
						lo_q  <= '0;
						hi_q  <= fill_q;
						if (!s_tuser[0] && (s_tdata[31:0] == '0 || s_tdata[71:32] == '0)) begin
							status_q <= ST_INVALID;
							state_q  <= S_FIN;
						end else if (s_tuser[0] && (s_tdata[31:0] == '0 || fill_q < CW'(2))) begin
							status_q <= ST_NOEST;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						hi_q    <= hi_q;
						state_q <= S_SRCH_CMP;
					end else if (lo_q < fill_q) begin
						state_q <= S_EQ_RD;
					end else if (cmd_q) begin
						status_q <= ST_NOEST;
						state_q  <= S_FIN;
					end else begin
						up_q    <= 1'b1;
						trim_q  <= 1'b0;
						src_q   <= fill_q - 1'b1;
						left_q  <= fill_q - lo_q;
						state_q <= S_COPY;
					end
				end
				S_SRCH_CMP: begin
					if (rd_key < id_q) lo_q <= mid + 1'b1;
					else hi_q <= mid;
					state_q <= S_SRCH_RD;
				end
				S_EQ_RD: state_q <= S_EQ_CHK;
				S_EQ_CHK: begin
					if (rd_key == id_q) begin
						if (cmd_q) begin
							status_q <= ST_EXACT;
							est_q    <= rd_time;
						end else begin
							status_q <= ST_DUP;
						end
						state_q <= S_FIN;
					end else if (!cmd_q) begin
						up_q    <= 1'b1;
						trim_q  <= 1'b0;
						src_q   <= fill_q - 1'b1;
						left_q  <= fill_q - lo_q;
						state_q <= S_COPY;
					end else if (lo_q == '0) begin
						status_q <= ST_NOEST;
						state_q  <= S_FIN;
					end else begin
						k1_q    <= rd_key;
						t1_q    <= rd_time;
						state_q <= S_EST_RD0;
					end
				end
				S_EST_RD0: state_q <= S_EST_CAPT;
				S_EST_CAPT: begin
					t0_q    <= rd_time;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (sc_done) begin
						est_q    <= (t1_q >= t0_q) ? t0_q + sc_quo : t0_q - sc_quo;
						status_q <= ST_INTERP;
						state_q  <= S_FIN;
					end
				end
				S_COPY: begin
					// Pipelined move: read one entry, write it to its new place in the next cycle.
					pa_q <= src_q;
					if (left_q != '0) begin
						pv_q   <= 1'b1;
						left_q <= left_q - 1'b1;
						src_q  <= up_q ? src_q - 1'b1 : src_q + 1'b1;
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							if (trim_q) begin
								fill_q   <= KEEP_C;
								status_q <= ST_TRIMMED;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_INS_WR;
							end
						end
					end
				end
				S_INS_WR: begin
					if (fill_q == CAP_C) begin
						up_q    <= 1'b0;
						trim_q  <= 1'b1;
						src_q   <= TRIM_C;
						left_q  <= KEEP_C;
						state_q <= S_COPY;
					end else begin
						fill_q   <= fill_q + 1'b1;
						status_q <= ST_INSERTED;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result register, loaded as the transaction is offered.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!m_tvalid || m_tready)) begin
			m_tuser <= status_q;
			m_tdata <= {3'b000, COUNT_W'(fill_q), est_q};
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_C)
		else $error("entry count above capacity");
	a_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NOEST || m_tuser == ST_INSERTED ||
		m_tuser == ST_TRIMMED || m_tuser == ST_DUP || m_tuser == ST_INVALID)
		|-> m_tdata[39:0] == '0)
		else $error("nonzero time on a result without an estimate");
	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> state_q == S_COPY || state_q == S_INS_WR)
		else $error("table write outside an insert");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/ssi_table.sv
// Sample table memory: one write port and one registered read port.
`default_nettype none
module ssi_table import ssi_pkg::*; (
	input  wire logic              clk,
	input  mem_req_t               req,
	output logic      [KEY_W-1:0]  rd_key,
	output logic      [TIME_W-1:0] rd_time
);
	logic [KEY_W-1:0]  key_mem  [DEPTH];
	logic [TIME_W-1:0] time_mem [DEPTH];

	// Write and registered read of both halves of an entry.
	always_ff @(posedge clk) begin
		if (req.we) begin
			key_mem[req.waddr]  <= req.wkey;
			time_mem[req.waddr] <= req.wtime;
		end
		rd_key  <= key_mem[req.raddr];
		rd_time <= time_mem[req.raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/ssi_scale.sv
// Bit-serial unit that computes floor(a * num / den) for num < den.
`default_nettype none
module ssi_scale import ssi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TIME_W-1:0] a,
	input  wire logic [KEY_W-1:0]  num,
	input  wire logic [KEY_W-1:0]  den,
	output logic                   done,
	output logic      [TIME_W-1:0] quo
);
	localparam int SW = $clog2(TIME_W + 1);

	logic              busy_q;
	logic [SW-1:0]     cnt_q;
	logic [TIME_W-1:0] a_q;
	logic [TIME_W-1:0] q_q;
	logic [KEY_W:0]    r_q;
	logic [KEY_W-1:0]  num_q;
	logic [KEY_W-1:0]  den_q;
	logic [KEY_W+1:0]  r2;
	logic [KEY_W+1:0]  den1;
	logic [KEY_W+1:0]  den2;

	// One bit of a per step: remainder doubles, adds num for a set bit, drops up to two den.
	always_comb begin
		den1 = {2'b00, den_q};
		den2 = {1'b0, den_q, 1'b0};
		r2 = {r_q, 1'b0} + (a_q[TIME_W-1] ? {2'b00, num_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(TIME_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			q_q   <= '0;
			r_q   <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			a_q <= {a_q[TIME_W-2:0], 1'b0};
			if (r2 >= den2) begin
				r_q <= (KEY_W+1)'(r2 - den2);
				q_q <= {q_q[TIME_W-2:0], 1'b0} + TIME_W'(2);
			end else if (r2 >= den1) begin
				r_q <= (KEY_W+1)'(r2 - den1);
				q_q <= {q_q[TIME_W-2:0], 1'b0} + TIME_W'(1);
			end else begin
				r_q <= (KEY_W+1)'(r2);
				q_q <= {q_q[TIME_W-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;

`ifndef NO_ASSERTIONS
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> r_q < {1'b0, den_q})
		else $error("scale remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("scale done without a running computation");
`endif
endmodule
`default_nettype wire
